[hw/rtl/lrst_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrst_pkg: shared types and constants for the range-add / range-sum tree
// Field widths, controller command codes and the command/status bundles.
// ----------------------------------------------------------------------------
package lrst_pkg;

  localparam int POS_W             = 11;   // position field width
  localparam int VAL_W             = 32;   // add amount width
  localparam int SUM_W             = 64;   // sum width
  localparam int MAX_POSITIONS_DEF = 1024;
  localparam int SIZE_RESET        = 1024;

  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_NOP    = 4'd0;
  localparam logic [OP_W-1:0] OP_CLR    = 4'd1;
  localparam logic [OP_W-1:0] OP_ACCEPT = 4'd2;
  localparam logic [OP_W-1:0] OP_ADD_A  = 4'd3;
  localparam logic [OP_W-1:0] OP_ADD_B  = 4'd4;
  localparam logic [OP_W-1:0] OP_STEP   = 4'd5;
  localparam logic [OP_W-1:0] OP_QB     = 4'd6;
  localparam logic [OP_W-1:0] OP_QA     = 4'd7;
  localparam logic [OP_W-1:0] OP_QMUL   = 4'd8;
  localparam logic [OP_W-1:0] OP_QPFX   = 4'd9;
  localparam logic [OP_W-1:0] OP_QFIN   = 4'd10;
  localparam logic [OP_W-1:0] OP_QEMPTY = 4'd11;

  typedef struct packed {
    logic [OP_W-1:0] op;
  } ctl_t;

  typedef struct packed {
    logic is_query;   // latched action is a query
    logic empty;      // clipped range is empty
    logic walk_go;    // current tree index still inside the walk
    logic clr_last;   // clearing sweep at its final entry
  } sts_t;

endpackage

[hw/rtl/lrst_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrst_dp: datapath of the range-add / range-sum tree
// Twin binary indexed trees in one memory, walk index, products, accumulators.
// ----------------------------------------------------------------------------
module lrst_dp
  import lrst_pkg::*;
#(
  parameter int MAX_POSITIONS = MAX_POSITIONS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [POS_W-1:0]        cfg_wdata,
  input  logic                    in_action,
  input  logic [POS_W-1:0]        in_range_low,
  input  logic [POS_W-1:0]        in_range_high,
  input  logic signed [VAL_W-1:0] in_add_value,
  input  ctl_t                    ctl,
  output sts_t                    sts,
  output logic                    out_valid,
  output logic signed [SUM_W-1:0] out_range_sum
);

  localparam int PW    = $clog2(MAX_POSITIONS + 2);
  localparam int XW    = (PW > POS_W) ? PW : POS_W;
  localparam int DEPTH = 2 ** PW;
  localparam int MW    = VAL_W + PW + 3;
  localparam logic [PW-1:0] NMAX = PW'(MAX_POSITIONS);
  localparam logic [PW-1:0] NRST = (SIZE_RESET > MAX_POSITIONS) ? PW'(MAX_POSITIONS)
                                                                : PW'(SIZE_RESET);

  logic [2*SUM_W-1:0] mem [DEPTH];

  logic               act_r, empty_r, out_valid_r;
  logic [PW-1:0]      lo_r, hi_r, pt_r, size_r, clr_r;
  logic [PW-1:0]      pt_nxt, clr_nxt, size_nxt;
  logic [PW:0]        idx_r, idx_nxt;
  logic [VAL_W-1:0]   val_r;
  logic [SUM_W-1:0]   d1_r, d2_r, s1_r, s2_r, mul_r, pfx_r, sum_r;
  logic [SUM_W-1:0]   d1_nxt, d2_nxt, s1_nxt, s2_nxt, mul_nxt, pfx_nxt, sum_nxt;
  logic [2*SUM_W-1:0] rd_r, wdata;
  logic [PW-1:0]      waddr;
  logic               mem_we, out_valid_nxt;

  logic [XW-1:0]      lo_x, hi_x, cfg_x;
  logic signed [VAL_W:0] vsel;
  logic [PW:0]        psel, lowbit, lim, ptp1;
  logic signed [MW-1:0] prod;

  // input clipping
  assign lo_x  = (in_range_low == '0) ? XW'(1) : XW'(in_range_low);
  assign hi_x  = (XW'(in_range_high) > XW'(size_r)) ? XW'(size_r) : XW'(in_range_high);
  assign cfg_x = XW'(cfg_wdata);

  always_comb begin
    if (cfg_wdata == '0) begin
      size_nxt = PW'(1);
    end else if (cfg_x > XW'(MAX_POSITIONS)) begin
      size_nxt = NMAX;
    end else begin
      size_nxt = PW'(cfg_x);
    end
  end

  // signed amount times position for the second tree
  assign vsel = (ctl.op == OP_ADD_B) ? -$signed({val_r[VAL_W-1], val_r})
                                     :  $signed({val_r[VAL_W-1], val_r});
  assign psel = (ctl.op == OP_ADD_B) ? ({1'b0, hi_r} + 1'b1) : {1'b0, lo_r};
  assign prod = vsel * $signed({1'b0, psel});

  assign lowbit = idx_r & (~idx_r + 1'b1);
  assign lim    = {1'b0, size_r} + 1'b1;
  assign ptp1   = {1'b0, pt_r} + 1'b1;

  assign sts.is_query = act_r;
  assign sts.empty    = empty_r;
  assign sts.clr_last = &clr_r;
  assign sts.walk_go  = act_r ? (idx_r != '0) : ((idx_r != '0) && (idx_r <= lim));

  always_comb begin
    idx_nxt       = idx_r;
    pt_nxt        = pt_r;
    d1_nxt        = d1_r;
    d2_nxt        = d2_r;
    s1_nxt        = s1_r;
    s2_nxt        = s2_r;
    mul_nxt       = mul_r;
    pfx_nxt       = pfx_r;
    sum_nxt       = sum_r;
    clr_nxt       = clr_r;
    mem_we        = 1'b0;
    waddr         = idx_r[PW-1:0];
    wdata         = {rd_r[2*SUM_W-1:SUM_W] + d1_r, rd_r[SUM_W-1:0] + d2_r};
    out_valid_nxt = 1'b0;
    case (ctl.op)
      OP_CLR: begin
        mem_we  = 1'b1;
        waddr   = clr_r;
        wdata   = '0;
        clr_nxt = clr_r + 1'b1;
      end
      OP_ADD_A, OP_ADD_B: begin
        idx_nxt = psel;
        d1_nxt  = {{(SUM_W-VAL_W-1){vsel[VAL_W]}}, vsel};
        d2_nxt  = {{(SUM_W-MW){prod[MW-1]}}, prod};
      end
      OP_STEP: begin
        if (act_r) begin
          s1_nxt  = s1_r + rd_r[2*SUM_W-1:SUM_W];
          s2_nxt  = s2_r + rd_r[SUM_W-1:0];
          idx_nxt = idx_r - lowbit;
        end else begin
          mem_we  = 1'b1;
          idx_nxt = idx_r + lowbit;
        end
      end
      OP_QB: begin
        idx_nxt = {1'b0, hi_r};
        pt_nxt  = hi_r;
        s1_nxt  = '0;
        s2_nxt  = '0;
      end
      OP_QA: begin
        idx_nxt = {1'b0, lo_r} - 1'b1;
        pt_nxt  = lo_r - 1'b1;
        s1_nxt  = '0;
        s2_nxt  = '0;
      end
      OP_QMUL: mul_nxt = s1_r * SUM_W'(ptp1);
      OP_QPFX: pfx_nxt = mul_r - s2_r;
      OP_QFIN: begin
        sum_nxt       = pfx_r - (mul_r - s2_r);
        out_valid_nxt = 1'b1;
      end
      OP_QEMPTY: begin
        sum_nxt       = '0;
        out_valid_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rd_r <= mem[idx_r[PW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r      <= NRST;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        size_r <= size_nxt;
        clr_r  <= '0;
      end else begin
        clr_r <= clr_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.op == OP_ACCEPT) begin
      act_r   <= in_action;
      val_r   <= in_add_value;
      lo_r    <= lo_x[PW-1:0];
      hi_r    <= hi_x[PW-1:0];
      empty_r <= lo_x > hi_x;
    end
    idx_r <= idx_nxt;
    pt_r  <= pt_nxt;
    d1_r  <= d1_nxt;
    d2_r  <= d2_nxt;
    s1_r  <= s1_nxt;
    s2_r  <= s2_nxt;
    mul_r <= mul_nxt;
    pfx_r <= pfx_nxt;
    sum_r <= sum_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_range_sum = sum_r;

endmodule

[hw/rtl/lrst_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrst_ctrl: sequencer of the range-add / range-sum tree
// Clears the store, then steps each transaction through its tree walks.
// ----------------------------------------------------------------------------
module lrst_ctrl
  import lrst_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic start,
  input  sts_t sts,
  output ctl_t ctl,
  output logic busy
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CLR  = 4'd1;
  localparam logic [3:0] S_DISP = 4'd2;
  localparam logic [3:0] S_ADDA = 4'd3;
  localparam logic [3:0] S_ADDB = 4'd4;
  localparam logic [3:0] S_RD   = 4'd5;
  localparam logic [3:0] S_STEP = 4'd6;
  localparam logic [3:0] S_QB   = 4'd7;
  localparam logic [3:0] S_QA   = 4'd8;
  localparam logic [3:0] S_QMUL = 4'd9;
  localparam logic [3:0] S_QPFX = 4'd10;
  localparam logic [3:0] S_QFIN = 4'd11;

  logic [3:0] state_r, state_nxt;
  logic       phase_r, phase_nxt;

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    ctl.op    = OP_NOP;
    case (state_r)
      S_IDLE: begin
        if (cfg_we) begin
          state_nxt = S_CLR;
        end else if (start) begin
          ctl.op    = OP_ACCEPT;
          state_nxt = S_DISP;
        end
      end
      S_CLR: begin
        ctl.op = OP_CLR;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_DISP: begin
        if (sts.empty) begin
          if (sts.is_query) begin
            ctl.op = OP_QEMPTY;
          end
          state_nxt = S_IDLE;
        end else begin
          state_nxt = sts.is_query ? S_QB : S_ADDA;
        end
      end
      S_ADDA: begin
        ctl.op    = OP_ADD_A;
        phase_nxt = 1'b0;
        state_nxt = S_RD;
      end
      S_ADDB: begin
        ctl.op    = OP_ADD_B;
        phase_nxt = 1'b1;
        state_nxt = S_RD;
      end
      S_QB: begin
        ctl.op    = OP_QB;
        phase_nxt = 1'b0;
        state_nxt = S_RD;
      end
      S_QA: begin
        ctl.op    = OP_QA;
        phase_nxt = 1'b1;
        state_nxt = S_RD;
      end
      S_RD: begin
        if (sts.walk_go) begin
          state_nxt = S_STEP;
        end else if (sts.is_query) begin
          state_nxt = S_QMUL;
        end else begin
          state_nxt = phase_r ? S_IDLE : S_ADDB;
        end
      end
      S_STEP: begin
        ctl.op    = OP_STEP;
        state_nxt = S_RD;
      end
      S_QMUL: begin
        ctl.op    = OP_QMUL;
        state_nxt = phase_r ? S_QFIN : S_QPFX;
      end
      S_QPFX: begin
        ctl.op    = OP_QPFX;
        state_nxt = S_QA;
      end
      S_QFIN: begin
        ctl.op    = OP_QFIN;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    if (cfg_we) begin
      state_nxt = S_CLR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      phase_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

[hw/rtl/lazy_range_add_range_sum_tree.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lazy_range_add_range_sum_tree: range add and range sum over positions
// Signed adds over inclusive ranges, 64-bit wrapping sums over ranges.
// ----------------------------------------------------------------------------
//
// channel  | handshake           | payload
// ---------+---------------------+---------------------------------------------
// input    | start & !busy       | in_action, in_range_low/high, in_add_value
// result   | out_valid, 1 cycle  | out_range_sum
// config   | cfg_we              | cfg_wdata (size in use)
//
// The store is a pair of binary indexed trees held in one memory of
// 2^ceil(log2(MAX_POSITIONS+2)) words; each walk step is a registered
// read, then a write-back or accumulate. Reset and every size write start
// a clearing sweep of one word a cycle over the whole memory, busy
// throughout. Results are presented for one cycle only; the receiver
// cannot stall.
//
module lazy_range_add_range_sum_tree
  import lrst_pkg::*;
#(
  parameter int MAX_POSITIONS = MAX_POSITIONS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // configuration
  input  logic                    cfg_we,
  input  logic [POS_W-1:0]        cfg_wdata,
  // input transaction
  input  logic                    start,
  output logic                    busy,
  input  logic                    in_action,
  input  logic [POS_W-1:0]        in_range_low,
  input  logic [POS_W-1:0]        in_range_high,
  input  logic signed [VAL_W-1:0] in_add_value,
  // result transaction
  output logic                    out_valid,
  output logic signed [SUM_W-1:0] out_range_sum
);

  ctl_t ctl;
  sts_t sts;

  // sequencer: owns the state, issues one command a cycle
  lrst_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg_we(cfg_we),
    .start (start),
    .sts   (sts),
    .ctl   (ctl),
    .busy  (busy)
  );

  // datapath: tree memory, walk index, products and sums
  lrst_dp #(
    .MAX_POSITIONS(MAX_POSITIONS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_action    (in_action),
    .in_range_low (in_range_low),
    .in_range_high(in_range_high),
    .in_add_value (in_add_value),
    .ctl          (ctl),
    .sts          (sts),
    .out_valid    (out_valid),
    .out_range_sum(out_range_sum)
  );

`ifndef SYNTHESIS
  // a result strobe is never held high
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  // an accepted transaction makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !cfg_we) |=> busy)
    else $error("accepted transaction did not raise busy");

  // a result only follows work done while busy
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without preceding work");
`endif

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the range-add / range-sum tree
// Drives add and query transactions in random bursts over several sizes in
// use, takes each range sum from the directed table or predicts it from a
// flat copy of the positions, and checks each result as it appears.
// ----------------------------------------------------------------------------
module testbench;
  import lrst_pkg::*;

  localparam int NPOS         = MAX_POSITIONS_DEF;
  localparam int SETTLE       = 80;     // longest walk of an add, with margin
  localparam bit ACT_ADD      = 1'b0;
  localparam bit ACT_QUERY    = 1'b1;
  localparam int RANDOM_ITEMS = 1300;

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_we;
  logic [POS_W-1:0]        cfg_wdata;
  logic                    start;
  logic                    busy;
  logic                    in_action;
  logic [POS_W-1:0]        in_range_low;
  logic [POS_W-1:0]        in_range_high;
  logic signed [VAL_W-1:0] in_add_value;
  logic                    out_valid;
  logic signed [SUM_W-1:0] out_range_sum;

  lazy_range_add_range_sum_tree u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .start        (start),
    .busy         (busy),
    .in_action    (in_action),
    .in_range_low (in_range_low),
    .in_range_high(in_range_high),
    .in_add_value (in_add_value),
    .out_valid    (out_valid),
    .out_range_sum(out_range_sum)
  );

  // One row of the directed table; the sum is typed in where it is obvious.
  typedef struct {
    bit                    action;
    logic [POS_W-1:0]      low;
    logic [POS_W-1:0]      high;
    logic [VAL_W-1:0]      amount;
    bit                    has_sum;
    logic [SUM_W-1:0]      sum;
  } row_t;

  // Flat image of every position and the size in use after clamping.
  logic [SUM_W-1:0] position_value [1:NPOS];
  int               span_size;
  logic [SUM_W-1:0] pending_sums [$];
  int               mismatches;
  int               burst_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("Mismatches found");
    $finish;
  end

  // Clamp a written size the way the block does and wipe the image.
  task automatic resize_image(input logic [POS_W-1:0] raw);
    span_size = (raw == 0) ? 1 : (raw > NPOS) ? NPOS : int'(raw);
    for (int p = 1; p <= NPOS; p++) position_value[p] = '0;
  endtask

  // Apply one transaction to the image; return the sum for a query.
  function automatic logic [SUM_W-1:0] apply_to_image(input bit action,
      input logic [POS_W-1:0] low, input logic [POS_W-1:0] high,
      input logic [VAL_W-1:0] amount);
    int               lo_c;
    int               hi_c;
    logic [SUM_W-1:0] acc;
    lo_c = (low == 0) ? 1 : int'(low);
    hi_c = (high > span_size) ? span_size : int'(high);
    acc  = '0;
    for (int p = lo_c; p <= hi_c; p++) begin
      if (action == ACT_ADD)
        position_value[p] += {{32{amount[31]}}, amount};
      else
        acc += position_value[p];
    end
    return acc;
  endfunction

  // Present one transaction from the falling edge, hold it until taken, and
  // record its expected sum. Gaps between bursts are random.
  task automatic send_item(input row_t r);
    logic [SUM_W-1:0] predicted;
    if (burst_left == 0) begin
      start = 1'b0;
      repeat ($urandom_range(0, 20)) @(negedge clk);
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    start         = 1'b1;
    in_action     = r.action;
    in_range_low  = r.low;
    in_range_high = r.high;
    in_add_value  = r.amount;
    do @(posedge clk); while (busy);
    predicted = apply_to_image(r.action, r.low, r.high, r.amount);
    if (r.action == ACT_QUERY)
      pending_sums.insert(pending_sums.size(), r.has_sum ? r.sum : predicted);
    @(negedge clk);
    if (burst_left == 0) start = 1'b0;
  endtask

  // Drain, let a trailing add finish, then write the size and clear the image.
  task automatic write_size(input logic [POS_W-1:0] raw);
    start = 1'b0;
    while (pending_sums.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    while (busy) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = raw;
    @(negedge clk);
    cfg_we = 1'b0;
    resize_image(raw);
  endtask

  // Random transaction; positions mostly inside the tree, sometimes outside.
  function automatic row_t random_row();
    row_t r;
    int   a;
    int   b;
    r.action = 1'($urandom_range(0, 1));
    a = $urandom_range(1, span_size);
    b = $urandom_range(1, span_size);
    if (a > b && $urandom_range(0, 9) != 0) begin
      int t;
      t = a; a = b; b = t;
    end
    if ($urandom_range(0, 19) == 0) a = $urandom_range(0, 2047);
    if ($urandom_range(0, 19) == 0) b = $urandom_range(0, 2047);
    r.low     = a[POS_W-1:0];
    r.high    = b[POS_W-1:0];
    r.amount  = $urandom();
    r.has_sum = 1'b0;
    r.sum     = '0;
    return r;
  endfunction

  // Check each one-cycle result against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_sums.size() == 0) begin
        $error("range_sum: unexpected result %0d", out_range_sum);
        mismatches++;
      end else begin
        logic [SUM_W-1:0] want;
        want = pending_sums.pop_front();
        if (out_range_sum !== want) begin
          $error("range_sum: expected %0d, actual %0d", $signed(want), out_range_sum);
          mismatches++;
        end
      end
    end
  end

  row_t directed [17] = '{
    '{ACT_QUERY, 11'd1,    11'd1024, 32'd0,          1'b1, 64'd0},
    '{ACT_QUERY, 11'd0,    11'd2047, 32'd0,          1'b1, 64'd0},
    '{ACT_ADD,   11'd1,    11'd1024, 32'h7FFF_FFFF,  1'b0, 64'd0},
    '{ACT_QUERY, 11'd1,    11'd1024, 32'd0,          1'b1, 64'd2199023254528},
    '{ACT_QUERY, 11'd0,    11'd2047, 32'd0,          1'b1, 64'd2199023254528},
    '{ACT_QUERY, 11'd5,    11'd3,    32'd0,          1'b1, 64'd0},
    '{ACT_ADD,   11'd900,  11'd10,   32'h1234_5678,  1'b0, 64'd0},
    '{ACT_QUERY, 11'd1,    11'd1,    32'd0,          1'b1, 64'd2147483647},
    '{ACT_ADD,   11'd1,    11'd1024, 32'h8000_0000,  1'b0, 64'd0},
    '{ACT_QUERY, 11'd1024, 11'd1024, 32'hFFFF_FFFF,  1'b1, 64'hFFFF_FFFF_FFFF_FFFF},
    '{ACT_QUERY, 11'd1,    11'd1024, 32'd0,          1'b1, -64'sd1024},
    '{ACT_ADD,   11'd0,    11'd512,  32'hDEAD_BEEF,  1'b0, 64'd0},
    '{ACT_ADD,   11'd300,  11'd2047, 32'h0000_0001,  1'b0, 64'd0},
    '{ACT_QUERY, 11'd256,  11'd700,  32'd0,          1'b0, 64'd0},
    '{ACT_QUERY, 11'd1025, 11'd2047, 32'd0,          1'b1, 64'd0},
    '{ACT_QUERY, 11'd0,    11'd0,    32'd0,          1'b1, 64'd0},
    '{ACT_QUERY, 11'd2,    11'd1023, 32'd0,          1'b0, 64'd0}
  };

  // Sizes visited after the reset value: extremes and odd splits included.
  logic [POS_W-1:0] sizes [8] = '{11'd1, 11'd0, 11'd2, 11'd2047, 11'd7, 11'd513,
                                  11'd100, 11'd1024};

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    start         = 1'b0;
    in_action     = ACT_ADD;
    in_range_low  = '0;
    in_range_high = '0;
    in_add_value  = '0;
    mismatches    = 0;
    burst_left    = 0;
    resize_image(11'(SIZE_RESET));
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    foreach (directed[i]) send_item(directed[i]);
    repeat (RANDOM_ITEMS / 3) send_item(random_row());

    // Spread the rest of the random transactions over the other sizes.
    foreach (sizes[s]) begin
      write_size(sizes[s]);
      repeat ((RANDOM_ITEMS * 2 / 3) / $size(sizes)) send_item(random_row());
    end

    start = 1'b0;
    while (pending_sums.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
